// ===== rtl/cre_pkg.sv =====
// Types and constants shared by the spline table evaluator.
`timescale 1ns / 1ps

package cre_pkg;

    localparam int CNT_W    = 7;
    localparam int KNOT_CAP = 64;
    localparam int PROD_W   = 68;
    localparam int MAG_W    = 34;
    localparam int ACC_W    = 70;
    localparam int OPND_W   = 35;
    localparam int T_W      = 31;
    localparam int D_W      = 34;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << 30;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_RANGE,
        ST_SRCH_ISSUE,
        ST_SRCH_CMP,
        ST_FETCH,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_STORE,
        ST_FINAL
    } state_t;

    typedef enum logic [3:0] {
        OP_D0,
        OP_D1,
        OP_T,
        OP_T2,
        OP_T3,
        OP_H00,
        OP_H01,
        OP_H10,
        OP_H11
    } op_t;

    typedef enum logic [1:0] {
        AS_ZERO,
        AS_LAST,
        AS_MID,
        AS_FETCH
    } addr_sel_t;

    typedef struct packed {
        logic      accept;
        addr_sel_t addr_sel;
        logic      cap_first;
        logic      cap_last;
        logic      srch_init;
        logic      srch_step;
        logic      set_idx;
        logic      fetch_cap;
        logic [1:0] fetch_k;
        logic [1:0] fetch_slot;
        logic      mul_lo;
        logic      mul_hi;
        logic      div_init;
        logic      div_step;
        logic      store;
        op_t       op;
        logic      load_out;
    } cmd_t;

    typedef struct packed {
        logic len_zero;
        logic in_range;
        logic div_last;
    } sts_t;

    function automatic logic [OPND_W-1:0] mag35(input logic signed [OPND_W-1:0] v);
        return v[OPND_W-1] ? OPND_W'(-v) : OPND_W'(v);
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

endpackage

// ===== rtl/cre_req_if.sv =====
// Request channel: knot loads and queries.
`timescale 1ns / 1ps

interface cre_req_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [5:0]         entry_index;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] query_x;

    modport source (output valid, kind, entry_index, node_x, node_y, query_x, input ready);
    modport sink   (input valid, kind, entry_index, node_x, node_y, query_x, output ready);
endinterface

// ===== rtl/cre_rsp_if.sv =====
// Response channel: interpolated value.
`timescale 1ns / 1ps

interface cre_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               in_range;

    modport source (output valid, value, in_range, input ready);
    modport sink   (input valid, value, in_range, output ready);
endinterface

// ===== rtl/cre_ctrl.sv =====
// Query sequencer: search, fetch, divide and polynomial steps.
`timescale 1ns / 1ps

module cre_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_kind,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  cre_pkg::sts_t sts,
    output cre_pkg::cmd_t cmd
);

    cre_pkg::state_t state_reg, state_next;
    cre_pkg::op_t    op_reg, op_next;
    logic [2:0]      fk_reg, fk_next;
    logic            rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cre_pkg::ST_IDLE;
            op_reg        <= cre_pkg::OP_D0;
            fk_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            fk_reg        <= fk_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        fk_next    = fk_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            cre_pkg::ST_IDLE:
            begin
                if (req_valid && req_kind == cre_pkg::KIND_QUERY)
                begin
                    state_next = cre_pkg::ST_RD_FIRST;
                end
            end
            cre_pkg::ST_RD_FIRST:  state_next = cre_pkg::ST_RD_LAST;
            cre_pkg::ST_RD_LAST:   state_next = cre_pkg::ST_RANGE;
            cre_pkg::ST_RANGE:
            begin
                state_next = sts.in_range ? cre_pkg::ST_SRCH_ISSUE : cre_pkg::ST_FINAL;
            end
            cre_pkg::ST_SRCH_ISSUE:
            begin
                if (sts.len_zero)
                begin
                    state_next = cre_pkg::ST_FETCH;
                    fk_next    = '0;
                end
                else
                begin
                    state_next = cre_pkg::ST_SRCH_CMP;
                end
            end
            cre_pkg::ST_SRCH_CMP:  state_next = cre_pkg::ST_SRCH_ISSUE;
            cre_pkg::ST_FETCH:
            begin
                fk_next = fk_reg + 3'd1;
                if (fk_reg == 3'd4)
                begin
                    state_next = cre_pkg::ST_MUL_LO;
                    op_next    = cre_pkg::OP_D0;
                end
            end
            cre_pkg::ST_MUL_LO:    state_next = cre_pkg::ST_MUL_HI;
            cre_pkg::ST_MUL_HI:
            begin
                if (op_reg == cre_pkg::OP_D0 || op_reg == cre_pkg::OP_D1 ||
                    op_reg == cre_pkg::OP_T)
                begin
                    state_next = cre_pkg::ST_DIV_INIT;
                end
                else
                begin
                    state_next = cre_pkg::ST_STORE;
                end
            end
            cre_pkg::ST_DIV_INIT:  state_next = cre_pkg::ST_DIV_RUN;
            cre_pkg::ST_DIV_RUN:
            begin
                if (sts.div_last)
                begin
                    state_next = cre_pkg::ST_STORE;
                end
            end
            cre_pkg::ST_STORE:
            begin
                state_next = cre_pkg::ST_MUL_LO;
                case (op_reg)
                    cre_pkg::OP_D0:  op_next = cre_pkg::OP_D1;
                    cre_pkg::OP_D1:  op_next = cre_pkg::OP_T;
                    cre_pkg::OP_T:   op_next = cre_pkg::OP_T2;
                    cre_pkg::OP_T2:  op_next = cre_pkg::OP_T3;
                    cre_pkg::OP_T3:  op_next = cre_pkg::OP_H00;
                    cre_pkg::OP_H00: op_next = cre_pkg::OP_H01;
                    cre_pkg::OP_H01: op_next = cre_pkg::OP_H10;
                    cre_pkg::OP_H10: op_next = cre_pkg::OP_H11;
                    default:
                    begin
                        op_next    = cre_pkg::OP_D0;
                        state_next = cre_pkg::ST_FINAL;
                    end
                endcase
            end
            cre_pkg::ST_FINAL:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next     = cre_pkg::ST_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default: state_next = cre_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.addr_sel   = cre_pkg::AS_ZERO;
        cmd.op         = op_reg;
        cmd.fetch_k    = fk_reg[1:0];
        cmd.fetch_slot = fk_reg[1:0] - 2'd1;
        req_ready      = 1'b0;
        case (state_reg)
            cre_pkg::ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            cre_pkg::ST_RD_FIRST: cmd.addr_sel = cre_pkg::AS_ZERO;
            cre_pkg::ST_RD_LAST:
            begin
                cmd.addr_sel  = cre_pkg::AS_LAST;
                cmd.cap_first = 1'b1;
            end
            cre_pkg::ST_RANGE:
            begin
                cmd.cap_last  = 1'b1;
                cmd.srch_init = sts.in_range;
            end
            cre_pkg::ST_SRCH_ISSUE:
            begin
                cmd.set_idx  = sts.len_zero;
                cmd.addr_sel = cre_pkg::AS_MID;
            end
            cre_pkg::ST_SRCH_CMP: cmd.srch_step = 1'b1;
            cre_pkg::ST_FETCH:
            begin
                cmd.addr_sel  = cre_pkg::AS_FETCH;
                cmd.fetch_cap = (fk_reg != 3'd0);
            end
            cre_pkg::ST_MUL_LO:   cmd.mul_lo   = 1'b1;
            cre_pkg::ST_MUL_HI:   cmd.mul_hi   = 1'b1;
            cre_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
            cre_pkg::ST_DIV_RUN:  cmd.div_step = 1'b1;
            cre_pkg::ST_STORE:    cmd.store    = 1'b1;
            cre_pkg::ST_FINAL:    cmd.load_out = !rsp_valid_reg || rsp_ready;
            default:              cmd.addr_sel = cre_pkg::AS_ZERO;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== rtl/cre_dp.sv =====
// Datapath: knot tables, search, shared multiplier, serial divider, Hermite sum.
`timescale 1ns / 1ps

module cre_dp #(
    parameter int MAX_KNOTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata,
    input  logic               kind,
    input  logic [5:0]         entry_index,
    input  logic signed [31:0] node_x,
    input  logic signed [31:0] node_y,
    input  logic signed [31:0] query_x,
    output logic signed [31:0] value,
    output logic               in_range,
    input  cre_pkg::cmd_t      cmd,
    output cre_pkg::sts_t      sts
);

    localparam int AW  = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int CAP = (MAX_KNOTS < cre_pkg::KNOT_CAP) ? MAX_KNOTS : cre_pkg::KNOT_CAP;
    localparam int PW  = cre_pkg::PROD_W;
    localparam int OW  = cre_pkg::OPND_W;
    localparam int DW  = cre_pkg::D_W;
    localparam int TW  = cre_pkg::T_W;
    localparam int CW  = cre_pkg::CNT_W;

    logic [6:0] pts_reg;
    logic signed [31:0] pos_mem [MAX_KNOTS];
    logic signed [31:0] val_mem [MAX_KNOTS];
    logic signed [31:0] pos_rd_reg, val_rd_reg;
    logic [AW-1:0] rd_addr;

    logic signed [31:0] q_reg, xfirst_reg;
    logic inr_reg;
    logic [CW-1:0] first_reg, len_reg, idx_reg;
    logic signed [31:0] xm1_reg, fm1_reg, x0_reg, f0_reg, x1_reg, f1_reg, x2_reg, f2_reg;
    logic [TW-1:0] t_reg, t2_reg, t3_reg;
    logic signed [DW-1:0] d0_reg, d1_reg;
    logic [PW-1:0] prod_reg, num_reg, quo_reg;
    logic [32:0] rem_reg;
    logic [CW-1:0] dcnt_reg;
    logic signed [cre_pkg::ACC_W-1:0] acc_reg;
    logic signed [31:0] value_reg;
    logic in_range_reg;

    logic [CW-1:0] n_use, mid, fetch_idx;
    logic signed [32:0] width, span;
    logic signed [OW-1:0] opa, opb, te, t2e, t3e, h00, h01, h10, h11;
    logic [OW-1:0] ma_full, mb_full;
    logic [cre_pkg::MAG_W-1:0] ma, mb;
    logic [16:0] chunk;
    logic [50:0] pp;
    logic neg_p, neg_d;
    logic [32:0] mc;
    logic [33:0] rem_sh;
    logic ge;
    logic [PW-1:0] lim;
    logic signed [DW-1:0] lo_v, hi_v, div_res;
    logic signed [DW-1:0] f_diff;
    logic signed [cre_pkg::ACC_W-1:0] sprod, rnd;
    logic signed [cre_pkg::ACC_W-31:0] res_w;
    logic signed [31:0] res_sat;

    always_comb
    begin
        if (pts_reg < 7'd2)
        begin
            n_use = 7'd2;
        end
        else if (pts_reg > 7'(CAP))
        begin
            n_use = 7'(CAP);
        end
        else
        begin
            n_use = pts_reg;
        end
    end

    assign mid       = first_reg + (len_reg >> 1);
    assign fetch_idx = idx_reg + CW'(cmd.fetch_k) - 7'd1;

    always_comb
    begin
        case (cmd.addr_sel)
            cre_pkg::AS_ZERO:  rd_addr = '0;
            cre_pkg::AS_LAST:  rd_addr = AW'(n_use - 7'd1);
            cre_pkg::AS_MID:   rd_addr = AW'(mid);
            cre_pkg::AS_FETCH: rd_addr = AW'(fetch_idx);
            default:           rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_reg <= 7'd2;
        end
        else if (cfg_we)
        begin
            pts_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && kind == cre_pkg::KIND_LOAD && 32'(entry_index) < MAX_KNOTS)
        begin
            pos_mem[AW'(entry_index)] <= node_x;
            val_mem[AW'(entry_index)] <= node_y;
        end
        pos_rd_reg <= pos_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
    end

    assign sts.in_range = !(q_reg < xfirst_reg || q_reg > pos_rd_reg);
    assign sts.len_zero = (len_reg == '0);
    assign sts.div_last = (dcnt_reg == CW'(PW - 1));

    // operand selection per step
    assign width = 33'(x1_reg) - 33'(x0_reg);
    assign f_diff = DW'(33'(f1_reg) - 33'(f0_reg));
    assign te  = OW'(t_reg);
    assign t2e = OW'(t2_reg);
    assign t3e = OW'(t3_reg);
    assign h00 = 35'sd2 * t3e - 35'sd3 * t2e + OW'(cre_pkg::T_ONE);
    assign h01 = 35'sd3 * t2e - 35'sd2 * t3e;
    assign h10 = t3e - 35'sd2 * t2e + te;
    assign h11 = t3e - t2e;

    always_comb
    begin
        case (cmd.op)
            cre_pkg::OP_D0:
            begin
                opa = OW'(width);
                opb = OW'(33'(f1_reg) - 33'(fm1_reg));
            end
            cre_pkg::OP_D1:
            begin
                opa = OW'(width);
                opb = OW'(33'(f2_reg) - 33'(f0_reg));
            end
            cre_pkg::OP_T:
            begin
                opa = OW'(33'(q_reg) - 33'(x0_reg));
                opb = OW'(cre_pkg::T_ONE);
            end
            cre_pkg::OP_T2:
            begin
                opa = te;
                opb = te;
            end
            cre_pkg::OP_T3:
            begin
                opa = t2e;
                opb = te;
            end
            cre_pkg::OP_H00:
            begin
                opa = h00;
                opb = OW'(f0_reg);
            end
            cre_pkg::OP_H01:
            begin
                opa = h01;
                opb = OW'(f1_reg);
            end
            cre_pkg::OP_H10:
            begin
                opa = h10;
                opb = OW'(d0_reg);
            end
            cre_pkg::OP_H11:
            begin
                opa = h11;
                opb = OW'(d1_reg);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.op)
            cre_pkg::OP_D0: span = 33'(x1_reg) - 33'(xm1_reg);
            cre_pkg::OP_D1: span = 33'(x2_reg) - 33'(x0_reg);
            default:        span = width;
        endcase
    end

    assign ma_full = cre_pkg::mag35(opa);
    assign mb_full = cre_pkg::mag35(opb);
    assign ma      = ma_full[cre_pkg::MAG_W-1:0];
    assign mb      = mb_full[cre_pkg::MAG_W-1:0];
    assign neg_p   = opa[OW-1] ^ opb[OW-1];
    assign chunk   = cmd.mul_hi ? mb[33:17] : mb[16:0];
    assign pp      = ma * chunk;

    assign mc     = cre_pkg::mag33(span);
    assign neg_d  = neg_p ^ span[32];
    assign rem_sh = {rem_reg, num_reg[PW-1]};
    assign ge     = rem_sh >= {1'b0, mc};

    always_comb
    begin
        if (cmd.op == cre_pkg::OP_T)
        begin
            lo_v = '0;
            hi_v = DW'(cre_pkg::T_ONE);
            lim  = neg_d ? '0 : PW'(cre_pkg::T_ONE);
        end
        else
        begin
            lo_v = {1'b1, {(DW-1){1'b0}}};
            hi_v = {1'b0, {(DW-1){1'b1}}};
            lim  = neg_d ? (PW'(1) << (DW - 1)) : PW'(hi_v);
        end
        if (prod_reg == '0)
        begin
            div_res = '0;
        end
        else if (mc == '0 || quo_reg > lim)
        begin
            div_res = neg_d ? lo_v : hi_v;
        end
        else
        begin
            div_res = neg_d ? -DW'(quo_reg[DW-1:0]) : DW'(quo_reg[DW-1:0]);
        end
    end

    assign sprod = neg_p ? -cre_pkg::ACC_W'(prod_reg) : cre_pkg::ACC_W'(prod_reg);

    assign rnd   = acc_reg + (cre_pkg::ACC_W'(1) << 29);
    assign res_w = rnd[cre_pkg::ACC_W-1:30];

    always_comb
    begin
        if (res_w > 40'sh007fffffff)
        begin
            res_sat = 32'sh7fffffff;
        end
        else if (res_w < -40'sh0080000000)
        begin
            res_sat = 32'sh80000000;
        end
        else
        begin
            res_sat = res_w[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inr_reg   <= 1'b0;
            first_reg <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            if (cmd.cap_last)
            begin
                inr_reg <= sts.in_range;
            end
            if (cmd.srch_init)
            begin
                first_reg <= '0;
                len_reg   <= n_use;
            end
            else if (cmd.srch_step)
            begin
                if (pos_rd_reg <= q_reg)
                begin
                    first_reg <= mid + 7'd1;
                    len_reg   <= len_reg - (len_reg >> 1) - 7'd1;
                end
                else
                begin
                    len_reg <= len_reg >> 1;
                end
            end
            if (cmd.set_idx)
            begin
                if (first_reg == '0)
                begin
                    idx_reg <= '0;
                end
                else if (first_reg == n_use)
                begin
                    idx_reg <= n_use - 7'd2;
                end
                else
                begin
                    idx_reg <= first_reg - 7'd1;
                end
            end
            if (cmd.div_init)
            begin
                dcnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            q_reg <= query_x;
        end
        if (cmd.cap_first)
        begin
            xfirst_reg <= pos_rd_reg;
        end
        if (cmd.fetch_cap)
        begin
            case (cmd.fetch_slot)
                2'd0:
                begin
                    xm1_reg <= pos_rd_reg;
                    fm1_reg <= val_rd_reg;
                end
                2'd1:
                begin
                    x0_reg <= pos_rd_reg;
                    f0_reg <= val_rd_reg;
                end
                2'd2:
                begin
                    x1_reg <= pos_rd_reg;
                    f1_reg <= val_rd_reg;
                end
                default:
                begin
                    x2_reg <= pos_rd_reg;
                    f2_reg <= val_rd_reg;
                end
            endcase
        end
        if (cmd.mul_lo)
        begin
            prod_reg <= PW'(pp);
        end
        else if (cmd.mul_hi)
        begin
            prod_reg <= prod_reg + (PW'(pp) << 17);
        end
        if (cmd.div_init)
        begin
            num_reg <= prod_reg;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? 33'(rem_sh - {1'b0, mc}) : rem_sh[32:0];
            quo_reg <= {quo_reg[PW-2:0], ge};
        end
        if (cmd.store)
        begin
            case (cmd.op)
                cre_pkg::OP_D0:  d0_reg <= (idx_reg != '0) ? div_res : f_diff;
                cre_pkg::OP_D1:  d1_reg <= (idx_reg + 7'd2 < n_use) ? div_res : f_diff;
                cre_pkg::OP_T:   t_reg  <= div_res[TW-1:0];
                cre_pkg::OP_T2:  t2_reg <= prod_reg[60:30];
                cre_pkg::OP_T3:  t3_reg <= prod_reg[60:30];
                cre_pkg::OP_H00: acc_reg <= sprod;
                default:         acc_reg <= acc_reg + sprod;
            endcase
        end
        if (cmd.load_out)
        begin
            value_reg    <= inr_reg ? res_sat : 32'sd0;
            in_range_reg <= inr_reg;
        end
    end

    assign value    = value_reg;
    assign in_range = in_range_reg;

endmodule

// ===== rtl/catmull_rom_table_eval.sv =====
// Top level of the Catmull-Rom knot table evaluator.
// A load word writes one knot and gives no response. A query word that
// falls outside the table reads the two end knots and then answers;
// otherwise it reads the end knots, takes up to seven binary search steps,
// fetches four knots, then runs each step of the evaluation through a
// shared 34x17 multiplier, with a bit-serial division after three of them
// (two tangents and t). The response sits in an output register, so a new
// word can be taken while the previous response waits.
`timescale 1ns / 1ps

module catmull_rom_table_eval #(
    parameter int MAX_KNOTS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [6:0] cfg_wdata,
    cre_req_if.sink   req,
    cre_rsp_if.source rsp
);

    cre_pkg::cmd_t cmd;
    cre_pkg::sts_t sts;

    cre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cre_dp #(
        .MAX_KNOTS (MAX_KNOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .kind        (req.kind),
        .entry_index (req.entry_index),
        .node_x      (req.node_x),
        .node_y      (req.node_y),
        .query_x     (req.query_x),
        .value       (rsp.value),
        .in_range    (rsp.in_range),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ===== rtl/cre_check.sv =====
// Port-level checks for the knot table evaluator, bound to the top level.
`timescale 1ns / 1ps

module cre_check (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        req_kind,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_value,
    input logic        rsp_in_range
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_in_range))
        else $error("response word changed while stalled");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_kind == cre_pkg::KIND_QUERY |=> !req_ready)
        else $error("request taken while a query is in work");

    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_in_range |-> rsp_value == 32'd0)
        else $error("out of range response carries a nonzero value");

    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response appeared without a query in work");

endmodule

bind catmull_rom_table_eval cre_check u_cre_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_kind     (req.kind),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_value    (rsp.value),
    .rsp_in_range (rsp.in_range)
);
